FILE: design/rmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg - shared types and constants
// Widths, branch codes and the beats carried between pipeline sections of
// the matrix-to-quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned DW      = 32;        // data width of every entry
  localparam int unsigned FW      = DW - 2;    // fraction bits (Q2.30)
  localparam int unsigned NW      = DW + 1;    // exact sum/difference of two entries
  localparam int unsigned RW      = DW + 3;    // signed radicand
  localparam int unsigned RadUW   = DW + 2;    // positive radicand
  localparam int unsigned SqSteps = DW;        // root bits, one per stage
  localparam int unsigned SqNW    = 2 * SqSteps; // radicand << FW
  localparam int unsigned SqRemW  = DW + 2;    // sqrt partial remainder
  localparam int unsigned SW      = DW + 1;    // s = 2 * root
  localparam int unsigned QW      = DW - 1;    // unsaturated quotient bits
  localparam int unsigned Lanes   = 3;         // divisions per item

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } br_e;

  typedef logic signed [NW-1:0] num_t;

  // side data riding along the square root pipeline
  typedef struct packed {
    logic [Lanes-1:0][NW-1:0] num;   // numerators, two's complement
    br_e                      br;
    logic                     degen;
  } sq_side_t;

  // side data riding along the divider pipeline
  typedef struct packed {
    logic [DW-2:0] main;             // root >> 1
    br_e           br;
    logic          degen;
  } dv_side_t;

  // one lane's division result
  typedef struct packed {
    logic          sat;
    logic          neg;
    logic [QW-1:0] quo;
  } quo_t;

endpackage
`default_nettype wire

FILE: design/rmq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_front - trace, branch pick and radicand
// One register stage: selects the formula, forms the radicand and the three
// numerators that feed the divider lanes.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [rmq_pkg::DW-1:0]     m00_i,
  input  logic signed [rmq_pkg::DW-1:0]     m01_i,
  input  logic signed [rmq_pkg::DW-1:0]     m02_i,
  input  logic signed [rmq_pkg::DW-1:0]     m10_i,
  input  logic signed [rmq_pkg::DW-1:0]     m11_i,
  input  logic signed [rmq_pkg::DW-1:0]     m12_i,
  input  logic signed [rmq_pkg::DW-1:0]     m20_i,
  input  logic signed [rmq_pkg::DW-1:0]     m21_i,
  input  logic signed [rmq_pkg::DW-1:0]     m22_i,
  output logic                              valid_o,
  output logic [rmq_pkg::RadUW-1:0]         rad_o,
  output rmq_pkg::sq_side_t                 side_o
);
  import rmq_pkg::*;

  localparam logic signed [RW-1:0] OneQ = RW'(1) << FW;

  logic signed [DW+1:0] tr;
  logic signed [RW-1:0] rad_t, rad_x, rad_y, rad_z, rad_sel;
  num_t     d21m12, d02m20, d10m01, s01p10, s02p20, s12p21;
  br_e      br;
  logic     degen;
  sq_side_t side_d;
  logic [RadUW-1:0] rad_d;
  logic     valid_q;
  logic [RadUW-1:0] rad_q;
  sq_side_t side_q;

  always_comb begin
    tr    = (DW+2)'(m00_i) + (DW+2)'(m11_i) + (DW+2)'(m22_i);
    rad_t = OneQ + RW'(tr);
    rad_x = OneQ + RW'(m00_i) - RW'(m11_i) - RW'(m22_i);
    rad_y = OneQ + RW'(m11_i) - RW'(m00_i) - RW'(m22_i);
    rad_z = OneQ + RW'(m22_i) - RW'(m00_i) - RW'(m11_i);

    d21m12 = num_t'(m21_i) - num_t'(m12_i);
    d02m20 = num_t'(m02_i) - num_t'(m20_i);
    d10m01 = num_t'(m10_i) - num_t'(m01_i);
    s01p10 = num_t'(m01_i) + num_t'(m10_i);
    s02p20 = num_t'(m02_i) + num_t'(m20_i);
    s12p21 = num_t'(m12_i) + num_t'(m21_i);

    if (tr > 0) begin
      br = BR_TRACE;
    end else if (m00_i > m11_i && m00_i > m22_i) begin
      br = BR_X;
    end else if (m11_i > m22_i) begin
      br = BR_Y;
    end else begin
      br = BR_Z;
    end

    // lanes hold the non-main parts in ascending index order
    unique case (br)
      BR_TRACE: begin
        rad_sel = rad_t;
        side_d.num = {d10m01, d02m20, d21m12};
      end
      BR_X: begin
        rad_sel = rad_x;
        side_d.num = {s02p20, s01p10, d21m12};
      end
      BR_Y: begin
        rad_sel = rad_y;
        side_d.num = {s12p21, s01p10, d02m20};
      end
      default: begin
        rad_sel = rad_z;
        side_d.num = {s12p21, s02p20, d10m01};
      end
    endcase

    degen        = rad_sel[RW-1] || (rad_sel == '0);
    rad_d        = degen ? RadUW'(1) : rad_sel[RadUW-1:0];
    side_d.br    = br;
    side_d.degen = degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

FILE: design/rmq_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt - pipelined integer square root
// floor(sqrt(rad << 30)), one root bit per register stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rmq_pkg::RadUW-1:0]   rad_i,
  input  rmq_pkg::sq_side_t           side_i,
  output logic                        valid_o,
  output logic [rmq_pkg::DW-1:0]      root_o,
  output rmq_pkg::sq_side_t           side_o
);
  import rmq_pkg::*;

  logic [SqNW-1:0]   n_q    [SqSteps];
  logic [SqRemW-1:0] r_q    [SqSteps];
  logic [DW-1:0]     q_q    [SqSteps];
  logic              v_q    [SqSteps];
  sq_side_t          side_q [SqSteps];

  for (genvar k = 0; k < SqSteps; k++) begin : g_stage
    logic [SqNW-1:0]   n_in;
    logic [SqRemW-1:0] r_in;
    logic [DW-1:0]     q_in;
    logic              v_in;
    sq_side_t          s_in;
    logic [SqRemW+1:0] rr, tt;
    logic              ge;

    if (k == 0) begin : g_first
      assign n_in = {rad_i, {FW{1'b0}}};
      assign r_in = '0;
      assign q_in = '0;
      assign v_in = valid_i;
      assign s_in = side_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
      assign q_in = q_q[k-1];
      assign v_in = v_q[k-1];
      assign s_in = side_q[k-1];
    end

    always_comb begin
      rr = {r_in, n_in[SqNW-1 -: 2]};
      tt = (SqRemW+2)'({q_in, 2'b01});
      ge = (rr >= tt);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_in << 2;
        r_q[k]    <= ge ? SqRemW'(rr - tt) : SqRemW'(rr);
        q_q[k]    <= {q_in[DW-2:0], ge};
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = v_q[SqSteps-1];
  assign root_o  = q_q[SqSteps-1];
  assign side_o  = side_q[SqSteps-1];

endmodule
`default_nettype wire

FILE: design/rmq_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div - three pipelined restoring dividers sharing one divisor
// num * 2^30 / (2 * root), truncated toward zero, with an overflow flag.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [rmq_pkg::DW-1:0]                  root_i,
  input  rmq_pkg::sq_side_t                       side_i,
  output logic                                    valid_o,
  output rmq_pkg::dv_side_t                       side_o,
  output rmq_pkg::quo_t [rmq_pkg::Lanes-1:0]      res_o
);
  import rmq_pkg::*;

  logic [SW-1:0] s_q    [QW];
  logic [SW-1:0] r_q    [QW][Lanes];
  quo_t          res_q  [QW][Lanes];
  logic          v_q    [QW];
  dv_side_t      side_q [QW];

  // entry stage: overflow check and the top quotient bit
  logic [SW-1:0] s0;
  dv_side_t      side0;
  assign s0 = {root_i, 1'b0};
  always_comb begin
    side0.main  = root_i[DW-1:1];
    side0.br    = side_i.br;
    side0.degen = side_i.degen;
  end

  for (genvar j = 0; j < Lanes; j++) begin : g_lane0
    num_t          num;
    logic          neg, top, ovf;
    logic [NW-1:0] mag;
    assign num = num_t'(side_i.num[j]);
    assign neg = num[NW-1];
    assign mag = neg ? NW'(-num) : NW'(num);
    assign ovf = ({1'b0, mag} >= {s0, 1'b0});
    assign top = (mag >= s0);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[0][j]       <= top ? SW'(mag - s0) : SW'(mag);
        res_q[0][j].sat <= ovf;
        res_q[0][j].neg <= neg;
        res_q[0][j].quo <= QW'(top);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0]    <= s0;
      side_q[0] <= side0;
    end
  end

  // one quotient bit per stage after that
  for (genvar k = 1; k < QW; k++) begin : g_stage
    for (genvar j = 0; j < Lanes; j++) begin : g_lane
      logic [SW:0] t;
      logic        ge;
      assign t  = {r_q[k-1][j], 1'b0};
      assign ge = (t >= {1'b0, s_q[k-1]});
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k][j]       <= ge ? SW'(t - {1'b0, s_q[k-1]}) : SW'(t);
          res_q[k][j].sat <= res_q[k-1][j].sat;
          res_q[k][j].neg <= res_q[k-1][j].neg;
          res_q[k][j].quo <= {res_q[k-1][j].quo[QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k]    <= s_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign side_o  = side_q[QW-1];
  for (genvar j = 0; j < Lanes; j++) begin : g_out
    assign res_o[j] = res_q[QW-1][j];
  end

endmodule
`default_nettype wire

FILE: design/rotation_matrix_to_quaternion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion - Shepperd matrix to unit quaternion
// Pipelined fixed-point converter, Q2.30 in and out.
// ----------------------------------------------------------------------------
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | in_valid_i, in_stall_o, m00_i..m22_i | in
//   output  | out_valid_o, out_stall_i, qw_o..qz_o,| out
//           | branch_used_o, degenerate_o          |
//
// One beat per clock sustained unless a held result is stalled. The pipe is
// one front stage, 32 square-root stages (one root bit each), 31 divider stages
// (one quotient bit each) and the output register.
// Reset clears only the valid bits; data registers are not reset.
// A stall on the output freezes the whole pipe while a result is held, and
// in_stall_o follows out_stall_i in that case; bubbles keep flowing.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [rmq_pkg::DW-1:0]  m00_i,
  input  logic signed [rmq_pkg::DW-1:0]  m01_i,
  input  logic signed [rmq_pkg::DW-1:0]  m02_i,
  input  logic signed [rmq_pkg::DW-1:0]  m10_i,
  input  logic signed [rmq_pkg::DW-1:0]  m11_i,
  input  logic signed [rmq_pkg::DW-1:0]  m12_i,
  input  logic signed [rmq_pkg::DW-1:0]  m20_i,
  input  logic signed [rmq_pkg::DW-1:0]  m21_i,
  input  logic signed [rmq_pkg::DW-1:0]  m22_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [rmq_pkg::DW-1:0]  qw_o,
  output logic signed [rmq_pkg::DW-1:0]  qx_o,
  output logic signed [rmq_pkg::DW-1:0]  qy_o,
  output logic signed [rmq_pkg::DW-1:0]  qz_o,
  output logic [1:0]                     branch_used_o,
  output logic                           degenerate_o
);
  import rmq_pkg::*;

  localparam logic signed [DW-1:0] MinQ = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MaxQ = ~MinQ;
  localparam logic signed [DW-1:0] OneQ = DW'(1) << FW;

  logic en;

  logic                fr_valid;
  logic [RadUW-1:0]    fr_rad;
  sq_side_t            fr_side;
  logic                sq_valid;
  logic [DW-1:0]       sq_root;
  sq_side_t            sq_side;
  logic                dv_valid;
  dv_side_t            dv_side;
  quo_t [Lanes-1:0]    dv_res;

  logic signed [DW-1:0] lane_val [Lanes];
  logic signed [DW-1:0] part     [4];
  logic signed [DW-1:0] fix      [4];

  logic                 valid_q;
  logic signed [DW-1:0] qw_q, qx_q, qy_q, qz_q;
  br_e                  br_q;
  logic                 degen_q;

  // whole pipe moves unless a held result is being stalled
  assign en         = !(valid_q && out_stall_i);
  assign in_stall_o = !en;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .m00_i   (m00_i),
    .m01_i   (m01_i),
    .m02_i   (m02_i),
    .m10_i   (m10_i),
    .m11_i   (m11_i),
    .m12_i   (m12_i),
    .m20_i   (m20_i),
    .m21_i   (m21_i),
    .m22_i   (m22_i),
    .valid_o (fr_valid),
    .rad_o   (fr_rad),
    .side_o  (fr_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .res_o   (dv_res)
  );

  // saturate each lane, drop the parts into place, then force w >= 0; degenerate beats get the identity
  always_comb begin
    for (int j = 0; j < Lanes; j++) begin
      if (dv_res[j].sat) begin
        lane_val[j] = dv_res[j].neg ? MinQ : MaxQ;
      end else if (dv_res[j].neg) begin
        lane_val[j] = -$signed({1'b0, dv_res[j].quo});
      end else begin
        lane_val[j] = $signed({1'b0, dv_res[j].quo});
      end
    end

    for (int i = 0; i < 4; i++) begin
      if (i == int'(dv_side.br)) begin
        part[i] = $signed({1'b0, dv_side.main});
      end else if (i < int'(dv_side.br)) begin
        part[i] = lane_val[i];
      end else begin
        part[i] = lane_val[i-1];
      end
    end

    for (int i = 0; i < 4; i++) begin
      if (dv_side.degen) begin
        fix[i] = (i == 0) ? OneQ : '0;
      end else if (part[0][DW-1]) begin
        fix[i] = (part[i] == MinQ) ? MaxQ : -part[i];
      end else begin
        fix[i] = part[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qw_q    <= fix[0];
      qx_q    <= fix[1];
      qy_q    <= fix[2];
      qz_q    <= fix[3];
      br_q    <= dv_side.br;
      degen_q <= dv_side.degen;
    end
  end

  assign out_valid_o   = valid_q;
  assign qw_o          = qw_q;
  assign qx_o          = qx_q;
  assign qy_o          = qy_q;
  assign qz_o          = qz_q;
  assign branch_used_o = br_q;
  assign degenerate_o  = degen_q;

  // degenerate beats carry the identity quaternion
  a_degen_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      qw_o == OneQ && qx_o == '0 && qy_o == '0 && qz_o == '0)
    else $error("degenerate beat is not identity");

  // scalar part is never negative
  a_w_nonneg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !qw_o[DW-1])
    else $error("qw negative");

  // trace formula never hits a non-positive radicand
  a_trace_not_degen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> branch_used_o != BR_TRACE)
    else $error("trace branch flagged degenerate");

  // a held result stays put while stalled
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(qw_o) && $stable(qz_o))
    else $error("held result changed under stall");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench - matrix-to-quaternion converter regression
// Drives matrices of directed and random content, predicts each quaternion
// bit for bit, and checks results in order under random valid and stall gaps.
// ----------------------------------------------------------------------------

// one predicted quaternion
typedef struct {
  logic signed [31:0] qw, qx, qy, qz;
  rmq_pkg::br_e       br;
  logic               degen;
} quat_t;

class quat_scoreboard;
  quat_t pending_q[$];
  int    errors;
  int    checked;

  static function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // truncating Q2.30 division with saturation
  static function automatic longint qdiv(longint num, logic [63:0] s);
    logic [63:0] mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag << 30) / s;
    if (num < 0) return (q >= 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
    return (q > 64'h7fff_ffff) ? 64'sh7fff_ffff : longint'(q);
  endfunction

  static function automatic longint sat32(longint v);
    if (v > 64'sh7fff_ffff) return 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function void note_matrix(logic signed [31:0] m[9]);
    longint a[9], tr, rad, q[4], mp;
    logic [63:0] root, s;
    quat_t e;
    for (int i = 0; i < 9; i++) a[i] = m[i];
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      e.br = rmq_pkg::BR_TRACE; rad = (64'sd1 << 30) + tr;
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      e.br = rmq_pkg::BR_X; rad = (64'sd1 << 30) + a[0] - a[4] - a[8];
    end else if (a[4] > a[8]) begin
      e.br = rmq_pkg::BR_Y; rad = (64'sd1 << 30) + a[4] - a[0] - a[8];
    end else begin
      e.br = rmq_pkg::BR_Z; rad = (64'sd1 << 30) + a[8] - a[0] - a[4];
    end
    e.degen = (rad <= 0);
    if (e.degen) begin
      q[0] = 64'sd1 << 30; q[1] = 0; q[2] = 0; q[3] = 0;
    end else begin
      root = isqrt(64'(rad) << 30);
      s = root * 2;
      mp = longint'(root >> 1);
      case (e.br)
        rmq_pkg::BR_TRACE: begin
          q[0] = mp; q[1] = qdiv(a[7] - a[5], s);
          q[2] = qdiv(a[2] - a[6], s); q[3] = qdiv(a[3] - a[1], s);
        end
        rmq_pkg::BR_X: begin
          q[0] = qdiv(a[7] - a[5], s); q[1] = mp;
          q[2] = qdiv(a[1] + a[3], s); q[3] = qdiv(a[2] + a[6], s);
        end
        rmq_pkg::BR_Y: begin
          q[0] = qdiv(a[2] - a[6], s); q[1] = qdiv(a[1] + a[3], s);
          q[2] = mp; q[3] = qdiv(a[5] + a[7], s);
        end
        default: begin
          q[0] = qdiv(a[3] - a[1], s); q[1] = qdiv(a[2] + a[6], s);
          q[2] = qdiv(a[5] + a[7], s); q[3] = mp;
        end
      endcase
      // keep w non-negative
      if (q[0] < 0) for (int i = 0; i < 4; i++) q[i] = sat32(-q[i]);
    end
    e.qw = q[0][31:0]; e.qx = q[1][31:0]; e.qy = q[2][31:0]; e.qz = q[3][31:0];
    pending_q.push_back(e);
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endfunction

  function void check_result(quat_t r);
    quat_t e;
    checked++;
    if (pending_q.size() == 0) begin
      report("unexpected beat", 0, 0);
      return;
    end
    e = pending_q.pop_front();
    if (r.qw !== e.qw) report("qw", r.qw, e.qw);
    if (r.qx !== e.qx) report("qx", r.qx, e.qx);
    if (r.qy !== e.qy) report("qy", r.qy, e.qy);
    if (r.qz !== e.qz) report("qz", r.qz, e.qz);
    if (r.br !== e.br) report("branch_used", r.br, e.br);
    if (r.degen !== e.degen) report("degenerate", r.degen, e.degen);
  endfunction
endclass

module testbench;
  localparam int Latency   = 65;
  localparam int WatchLimit = 20000;
  localparam int RandItems = 700;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic out_stall_i = 0;
  logic signed [31:0] m_drv[9];
  wire  in_stall_o, out_valid_o;
  wire  signed [31:0] qw_o, qx_o, qy_o, qz_o;
  wire  [1:0] branch_used_o;
  wire  degenerate_o;

  quat_scoreboard sb = new();
  int  idle_pct = 23;   // chance in percent of a gap on either side
  int  quiet = 0;       // cycles with no accepted beat
  int  in_count = 0;
  int  branch_seen[4];
  int  degen_seen = 0;

  always #1 clk_i = ~clk_i;

  initial for (int i = 0; i < 9; i++) m_drv[i] = 0;

  rotation_matrix_to_quaternion DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .m00_i(m_drv[0]), .m01_i(m_drv[1]), .m02_i(m_drv[2]),
    .m10_i(m_drv[3]), .m11_i(m_drv[4]), .m12_i(m_drv[5]),
    .m20_i(m_drv[6]), .m21_i(m_drv[7]), .m22_i(m_drv[8]),
    .out_valid_o, .out_stall_i, .qw_o, .qx_o, .qy_o, .qz_o,
    .branch_used_o, .degenerate_o
  );

  // result side: random stall, check each accepted beat
  always @(posedge clk_i) begin
    quat_t r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        r.qw = qw_o; r.qx = qx_o; r.qy = qy_o; r.qz = qz_o;
        r.br = rmq_pkg::br_e'(branch_used_o); r.degen = degenerate_o;
        sb.check_result(r);
        branch_seen[branch_used_o]++;
        if (degenerate_o) degen_seen++;
      end
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // watchdog: no beat in either direction for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end
  end

  // send one matrix, with an optional random gap first; called at a rising
  // edge, returns at the edge that accepted the beat so the next can follow
  task automatic send_matrix(logic signed [31:0] m[9]);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    for (int i = 0; i < 9; i++) m_drv[i] <= m[i];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_matrix(m);
    in_count++;
  endtask

  function automatic logic signed [31:0] rnd_entry();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
    endcase
  endfunction

  // near-rotation: random unit quaternion with small jitter
  task automatic rotation_matrix(output logic signed [31:0] m[9]);
    real w, x, y, z, n;
    real r[9];
    w = $signed($urandom) / 2147483648.0; x = $signed($urandom) / 2147483648.0;
    y = $signed($urandom) / 2147483648.0; z = $signed($urandom) / 2147483648.0;
    n = $sqrt(w*w + x*x + y*y + z*z) + 1e-9;
    w /= n; x /= n; y /= n; z /= n;
    r[0] = 1 - 2*(y*y + z*z); r[1] = 2*(x*y - z*w); r[2] = 2*(x*z + y*w);
    r[3] = 2*(x*y + z*w); r[4] = 1 - 2*(x*x + z*z); r[5] = 2*(y*z - x*w);
    r[6] = 2*(x*z - y*w); r[7] = 2*(y*z + x*w); r[8] = 1 - 2*(x*x + y*y);
    for (int i = 0; i < 9; i++)
      m[i] = $rtoi(r[i] * 1073741824.0) + $signed($urandom_range(64)) - 32;
  endtask

  initial begin
    logic signed [31:0] m[9];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;

    // directed: identity, each diagonal branch, ties, extremes
    m = '{32'sh4000_0000, 0, 0, 0, 32'sh4000_0000, 0, 0, 0, 32'sh4000_0000};
    send_matrix(m);
    m = '{32'sh4000_0000, 0, 0, 0, -32'sh4000_0000, 0, 0, 0, -32'sh4000_0000};
    send_matrix(m);   // 180 deg about x
    m = '{-32'sh4000_0000, 0, 0, 0, 32'sh4000_0000, 0, 0, 0, -32'sh4000_0000};
    send_matrix(m);   // about y
    m = '{-32'sh4000_0000, 0, 0, 0, -32'sh4000_0000, 0, 0, 0, 32'sh4000_0000};
    send_matrix(m);   // about z
    m = '{-32'sh2000_0000, 5, 7, 9, -32'sh2000_0000, 11, 13, 17, -32'sh2000_0000};
    send_matrix(m);   // three-way tie on the diagonal
    m = '{0, 1, 2, 3, 0, 4, 5, 6, -32'sh1000_0000};
    send_matrix(m);   // x/y tie, trace negative
    m = '{default: 32'sh8000_0000};
    send_matrix(m);   // most negative, z wins the tie
    m = '{default: 32'sh7fff_ffff};
    send_matrix(m);   // most positive, trace path
    m = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
          32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
          32'sh8000_0000};
    send_matrix(m);   // x branch, extreme entries, quotients stay unsaturated
    m = '{0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 0,
          32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 1};
    send_matrix(m);   // small trace, huge off-diagonals
    m = '{-32'sh4000_0000, 0, 0, 0, -32'sh4000_0000, 0, 0, 0, -32'sh4000_0000};
    send_matrix(m);   // negative identity, z wins the tie
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(m);   // trace zero

    // pause until the pipe drains, then resume
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);

    for (int k = 0; k < RandItems; k++) begin
      // no idling through one long stretch
      idle_pct = (k >= 300 && k < 420) ? 0 : 23;
      if ($urandom_range(99) < 75) rotation_matrix(m);
      else for (int i = 0; i < 9; i++) m[i] = rnd_entry();
      send_matrix(m);
    end

    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);

    $display("sent %0d matrices, checked %0d quaternions", in_count, sb.checked);
    $display("branches trace/x/y/z %0d/%0d/%0d/%0d, degenerate %0d",
             branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3], degen_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion.sv
sim/testbench.sv
